/* rtl/prim_mst_pkg.sv */
`timescale 1ns / 1ps

package prim_mst_pkg;

  // widths fixed by the request and result formats
  localparam int NODE_W      = 5;
  localparam int WEIGHT_IN_W = 16;
  localparam int CFG_W       = 6;

  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 6'd32;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_BUILD = 2'd2
  } req_type_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE2,
    ST_FETCH,
    ST_MEMBER,
    ST_SCAN,
    ST_SETTLE,
    ST_JOIN,
    ST_PARENT,
    ST_EMIT_RD,
    ST_EMIT_LD
  } mst_state_t;

endpackage

/* rtl/prim_max_spanning_tree_top.sv */
`timescale 1ns / 1ps

// Dense maximum spanning tree engine. Edge weights live in a one-port-write,
// one-port-read synchronous RAM addressed {row, col}; a second small RAM holds
// the join order and the parent of every node. A clear request, and reset,
// sweep all 2**(2*ceil(log2(MAX_NODES))) weight RAM entries, 1024 at the
// default size, one entry per cycle, with the input stalled meanwhile. A write
// request writes entry {a, b} and then its mirror {b, a}; a dropped one writes
// neither. A build request is busy for one weight RAM read per (tree member,
// node) pair of every growth step, then for one parent result per node.
// Requests are taken one at a time; the last result of a build may still wait
// in the output register while the next request is taken.
module prim_max_spanning_tree_top
  import prim_mst_pkg::*;
#(
  parameter int MAX_NODES   = 32,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wr_data,

  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_req_type,
  input  logic [NODE_W-1:0]      in_node_a,
  input  logic [NODE_W-1:0]      in_node_b,
  input  logic [WEIGHT_IN_W-1:0] in_weight,

  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [NODE_W-1:0]      out_node,
  output logic [NODE_W-1:0]      out_parent,
  output logic                   out_is_root,
  output logic                   out_last
);

  localparam int NIW    = $clog2(MAX_NODES);
  localparam int CW     = $clog2(MAX_NODES + 1);
  localparam int WA     = 2 * NIW;
  localparam int TA     = NIW + 1;
  localparam int WDEPTH = 1 << WA;
  localparam int TDEPTH = 1 << TA;

  // memories
  logic [WEIGHT_BITS-1:0] wt_mem [WDEPTH];
  logic [NIW-1:0]         tree_mem [TDEPTH];
  logic [WEIGHT_BITS-1:0] wt_rd_r;
  logic [NIW-1:0]         tree_rd_r;

  logic                   wt_we;
  logic [WA-1:0]          wt_waddr;
  logic [WA-1:0]          wt_raddr;
  logic [WEIGHT_BITS-1:0] wt_wdata;
  logic                   tree_we;
  logic [TA-1:0]          tree_waddr;
  logic [TA-1:0]          tree_raddr;
  logic [NIW-1:0]         tree_wdata;

  // control and datapath registers
  mst_state_t             state_r, state_nxt;
  logic [CFG_W-1:0]       node_count_r;
  logic [WA-1:0]          clr_r, clr_nxt;
  logic [NIW-1:0]         k_r, k_nxt;
  logic [NIW-1:0]         v_r, v_nxt;
  logic [CW-1:0]          size_r, size_nxt;
  logic [CW-1:0]          n_r, n_nxt;
  logic [NIW-1:0]         m_r, m_nxt;
  logic [WEIGHT_BITS-1:0] best_r, best_nxt;
  logic [NIW-1:0]         from_r, from_nxt;
  logic [NIW-1:0]         to_r, to_nxt;
  logic [MAX_NODES-1:0]   in_tree_r, in_tree_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [NIW-1:0]         cmp_v_r, cmp_v_nxt;
  logic [NIW-1:0]         a_r, a_nxt;
  logic [NIW-1:0]         b_r, b_nxt;
  logic [WEIGHT_BITS-1:0] w_r, w_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]      out_node_r, out_node_nxt;
  logic [NODE_W-1:0]      out_parent_r, out_parent_nxt;
  logic                   out_is_root_r, out_is_root_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   in_acc;
  logic                   out_acc;
  logic [CW-1:0]          n_cfg;
  logic                   edge_ok;
  logic [NIW-1:0]         in_a_idx;
  logic [NIW-1:0]         in_b_idx;
  logic [31:0]            w_ext;
  logic [WEIGHT_BITS-1:0] in_w;
  logic                   v_last;
  logic                   k_last;
  logic                   out_free;

  assign in_stall    = (state_r != ST_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign out_acc     = out_valid_r && !out_stall;
  assign out_free    = !out_valid_r || !out_stall;
  assign out_valid   = out_valid_r;
  assign out_node    = out_node_r;
  assign out_parent  = out_parent_r;
  assign out_is_root = out_is_root_r;
  assign out_last    = out_last_r;

  assign in_a_idx = NIW'(in_node_a);
  assign in_b_idx = NIW'(in_node_b);
  assign w_ext    = 32'(in_weight);
  assign in_w     = w_ext[WEIGHT_BITS-1:0];
  assign edge_ok  = (in_node_a != in_node_b) && (32'(in_node_a) < MAX_NODES)
                    && (32'(in_node_b) < MAX_NODES);
  assign v_last   = (CW'(v_r) + CW'(1)) == n_r;
  assign k_last   = (CW'(k_r) + CW'(1)) == size_r;

  // node count clamped to 1..MAX_NODES
  always_comb begin
    if (node_count_r == '0) begin
      n_cfg = CW'(1);
    end else if (32'(node_count_r) > MAX_NODES) begin
      n_cfg = CW'(MAX_NODES);
    end else begin
      n_cfg = CW'(node_count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (wt_we) begin
      wt_mem[wt_waddr] <= wt_wdata;
    end
    wt_rd_r <= wt_mem[wt_raddr];
  end

  always_ff @(posedge clk) begin
    if (tree_we) begin
      tree_mem[tree_waddr] <= tree_wdata;
    end
    tree_rd_r <= tree_mem[tree_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      node_count_r <= NODE_COUNT_RST;
      clr_r        <= '0;
      in_tree_r    <= '0;
      size_r       <= '0;
      cmp_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      in_tree_r   <= in_tree_nxt;
      size_r      <= size_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        node_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r           <= k_nxt;
    v_r           <= v_nxt;
    n_r           <= n_nxt;
    m_r           <= m_nxt;
    best_r        <= best_nxt;
    from_r        <= from_nxt;
    to_r          <= to_nxt;
    cmp_v_r       <= cmp_v_nxt;
    a_r           <= a_nxt;
    b_r           <= b_nxt;
    w_r           <= w_nxt;
    out_node_r    <= out_node_nxt;
    out_parent_r  <= out_parent_nxt;
    out_is_root_r <= out_is_root_nxt;
    out_last_r    <= out_last_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    k_nxt           = k_r;
    v_nxt           = v_r;
    size_nxt        = size_r;
    n_nxt           = n_r;
    m_nxt           = m_r;
    best_nxt        = best_r;
    from_nxt        = from_r;
    to_nxt          = to_r;
    in_tree_nxt     = in_tree_r;
    cmp_vld_nxt     = 1'b0;
    cmp_v_nxt       = cmp_v_r;
    a_nxt           = a_r;
    b_nxt           = b_r;
    w_nxt           = w_r;
    out_valid_nxt   = out_acc ? 1'b0 : out_valid_r;
    out_node_nxt    = out_node_r;
    out_parent_nxt  = out_parent_r;
    out_is_root_nxt = out_is_root_r;
    out_last_nxt    = out_last_r;

    wt_we      = 1'b0;
    wt_waddr   = {in_a_idx, in_b_idx};
    wt_wdata   = in_w;
    wt_raddr   = {m_r, v_r};
    tree_we    = 1'b0;
    tree_waddr = '0;
    tree_wdata = '0;
    tree_raddr = {1'b0, k_r};

    // compare stage, in the cycle after the weight read
    if (cmp_vld_r && !in_tree_r[cmp_v_r] && (wt_rd_r >= best_r)) begin
      best_nxt = wt_rd_r;
      from_nxt = m_r;
      to_nxt   = cmp_v_r;
    end

    unique case (state_r)
      ST_CLEAR: begin
        wt_we    = 1'b1;
        wt_waddr = clr_r;
        wt_wdata = '0;
        clr_nxt  = clr_r + WA'(1);
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_req_type)
            REQ_CLEAR: begin
              clr_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
            REQ_WRITE: begin
              a_nxt = in_a_idx;
              b_nxt = in_b_idx;
              w_nxt = in_w;
              if (edge_ok) begin
                wt_we     = 1'b1;
                state_nxt = ST_WRITE2;
              end
            end
            REQ_BUILD: begin
              n_nxt          = n_cfg;
              size_nxt       = CW'(1);
              in_tree_nxt    = '0;
              in_tree_nxt[0] = 1'b1;
              k_nxt          = '0;
              v_nxt          = '0;
              best_nxt       = '0;
              tree_we        = 1'b1;
              tree_waddr     = '0;
              tree_wdata     = '0;
              state_nxt      = (n_cfg == CW'(1)) ? ST_EMIT_RD : ST_FETCH;
            end
            default: begin
            end
          endcase
        end
      end
      ST_WRITE2: begin
        wt_we     = 1'b1;
        wt_waddr  = {b_r, a_r};
        wt_wdata  = w_r;
        state_nxt = ST_IDLE;
      end
      ST_FETCH: begin
        tree_raddr = {1'b0, k_r};
        state_nxt  = ST_MEMBER;
      end
      ST_MEMBER: begin
        m_nxt     = tree_rd_r;
        v_nxt     = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        wt_raddr    = {m_r, v_r};
        cmp_vld_nxt = 1'b1;
        cmp_v_nxt   = v_r;
        v_nxt       = v_r + NIW'(1);
        if (v_last) begin
          v_nxt = '0;
          if (k_last) begin
            state_nxt = ST_SETTLE;
          end else begin
            k_nxt     = k_r + NIW'(1);
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_SETTLE: begin
        // last compare of the step lands this cycle
        state_nxt = ST_JOIN;
      end
      ST_JOIN: begin
        tree_we             = 1'b1;
        tree_waddr          = {1'b0, NIW'(size_r)};
        tree_wdata          = to_r;
        in_tree_nxt[to_r]   = 1'b1;
        state_nxt           = ST_PARENT;
      end
      ST_PARENT: begin
        tree_we    = 1'b1;
        tree_waddr = {1'b1, to_r};
        tree_wdata = from_r;
        size_nxt   = size_r + CW'(1);
        k_nxt      = '0;
        v_nxt      = '0;
        best_nxt   = '0;
        if ((size_r + CW'(1)) == n_r) begin
          state_nxt = ST_EMIT_RD;
        end else begin
          state_nxt = ST_FETCH;
        end
      end
      ST_EMIT_RD: begin
        tree_raddr = {1'b1, v_r};
        state_nxt  = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        tree_raddr = {1'b1, v_r};
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_node_nxt    = NODE_W'(v_r);
          out_is_root_nxt = (v_r == '0);
          out_parent_nxt  = (v_r == '0) ? '0 : NODE_W'(tree_rd_r);
          out_last_nxt    = v_last;
          v_nxt           = v_r + NIW'(1);
          state_nxt       = v_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // a node picked to join was not yet in the tree
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_JOIN) |-> !in_tree_r[to_r])
    else $error("join target already in tree");

  // membership flags and tree size agree at the start of every member fetch
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH) |-> ($countones(in_tree_r) == 32'(size_r)))
    else $error("tree size does not match membership");

  // weight RAM is never written while a growth step reads it
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_MEMBER || state_r == ST_SETTLE) |-> !wt_we)
    else $error("weight write during scan");

  // a result is only loaded into a free or draining output register
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_node_r)))
    else $error("pending result overwritten");

endmodule

/* bench/mst_checker.sv */
`timescale 1ns / 1ps

module mst_checker
  import prim_mst_pkg::*;
#(
  parameter int MAX_N = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wr_data,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [1:0]             in_req_type,
  input  logic [NODE_W-1:0]      in_node_a,
  input  logic [NODE_W-1:0]      in_node_b,
  input  logic [WEIGHT_IN_W-1:0] in_weight,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [NODE_W-1:0]      out_node,
  input  logic [NODE_W-1:0]      out_parent,
  input  logic                   out_is_root,
  input  logic                   out_last,
  output int                     errors,
  output int                     pending
);

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] parent;
    logic              is_root;
    logic              last;
  } parent_rec_t;

  parent_rec_t parents_due[$];
  parent_rec_t want;
  logic [WEIGHT_IN_W-1:0] wt [MAX_N][MAX_N];
  logic [CFG_W-1:0] node_count_q;

  // grow the tree from node 0 and queue one parent record per active node
  function void grow_parents();
    logic [MAX_N-1:0]      joined;
    logic [NODE_W-1:0]     order [MAX_N];
    logic [NODE_W-1:0]     par [MAX_N];
    logic [WEIGHT_IN_W-1:0] best;
    logic [NODE_W-1:0]     from_node;
    logic [NODE_W-1:0]     to_node;
    logic                  hit;
    parent_rec_t           rec;
    int                    n;
    int                    size;
    n = (node_count_q == 0) ? 1 : (node_count_q > MAX_N) ? MAX_N : int'(node_count_q);
    joined    = '0;
    joined[0] = 1'b1;
    order[0]  = '0;
    par[0]    = '0;
    size      = 1;
    while (size < n) begin
      best      = '0;
      from_node = '0;
      to_node   = '0;
      hit       = 1'b0;
      // members in join order, candidates ascending; ties go to the later one
      for (int k = 0; k < size; k++) begin
        for (int v = 0; v < n; v++) begin
          if (!joined[v] && wt[order[k]][v] >= best) begin
            best      = wt[order[k]][v];
            from_node = order[k];
            to_node   = NODE_W'(v);
            hit       = 1'b1;
          end
        end
      end
      if (!hit) break;
      par[to_node]    = from_node;
      joined[to_node] = 1'b1;
      order[size]     = to_node;
      size++;
    end
    for (int v = 0; v < n; v++) begin
      rec.node    = NODE_W'(v);
      rec.parent  = (v == 0) ? '0 : par[v];
      rec.is_root = (v == 0);
      rec.last    = (v == n - 1);
      parents_due.push_back(rec);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < MAX_N; r++) begin
        for (int c = 0; c < MAX_N; c++) begin
          wt[r][c] = '0;
        end
      end
      node_count_q = NODE_COUNT_RST;
      parents_due.delete();
    end else begin
      if (cfg_wr_en) begin
        node_count_q = cfg_wr_data;
      end
      if (out_valid && !out_stall) begin
        if (parents_due.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("mst_checker: unexpected result node %0d parent %0d root %0d last %0d",
                     out_node, out_parent, out_is_root, out_last);
          end
        end else begin
          want = parents_due.pop_front();
          if (out_node !== want.node || out_parent !== want.parent ||
              out_is_root !== want.is_root || out_last !== want.last) begin
            errors++;
            if (errors <= 10) begin
              $display("mst_checker: mismatch exp node %0d parent %0d root %0d last %0d",
                       want.node, want.parent, want.is_root, want.last);
              $display("mst_checker:          got node %0d parent %0d root %0d last %0d",
                       out_node, out_parent, out_is_root, out_last);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (in_req_type)
          REQ_CLEAR: begin
            for (int r = 0; r < MAX_N; r++) begin
              for (int c = 0; c < MAX_N; c++) begin
                wt[r][c] = '0;
              end
            end
          end
          REQ_WRITE: begin
            if (in_node_a != in_node_b) begin
              wt[in_node_a][in_node_b] = in_weight;
              wt[in_node_b][in_node_a] = in_weight;
            end
          end
          REQ_BUILD: begin
            grow_parents();
          end
          default: begin
          end
        endcase
      end
    end
    pending = parents_due.size();
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top
  import prim_mst_pkg::*;
();

  localparam int MAX_N        = 32;
  localparam int SETTLE_CYC   = 1100;   // longer than a full weight sweep
  localparam int LONG_HOLD    = 1500;
  localparam int WATCHDOG     = 100000;
  localparam int RANDOM_ITEMS = 420;
  localparam int QUIET_TAIL   = 40;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [CFG_W-1:0]       cfg_wr_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [1:0]             in_req_type;
  logic [NODE_W-1:0]      in_node_a;
  logic [NODE_W-1:0]      in_node_b;
  logic [WEIGHT_IN_W-1:0] in_weight;
  logic                   out_valid;
  logic                   out_stall;
  logic [NODE_W-1:0]      out_node;
  logic [NODE_W-1:0]      out_parent;
  logic                   out_is_root;
  logic                   out_last;

  int errors;
  int pending;
  int idle_cycles = 0;
  int node_limit  = MAX_N;
  bit calm        = 1'b0;
  bit quiet       = 1'b0;
  bit long_hold   = 1'b0;

  prim_max_spanning_tree_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_node_a   (in_node_a),
    .in_node_b   (in_node_b),
    .in_weight   (in_weight),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_node    (out_node),
    .out_parent  (out_parent),
    .out_is_root (out_is_root),
    .out_last    (out_last)
  );

  mst_checker #(.MAX_N(MAX_N)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_node_a   (in_node_a),
    .in_node_b   (in_node_b),
    .in_weight   (in_weight),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_node    (out_node),
    .out_parent  (out_parent),
    .out_is_root (out_is_root),
    .out_last    (out_last),
    .errors      (errors),
    .pending     (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (!calm && !quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send(input logic [1:0] rt, input logic [NODE_W-1:0] a,
                      input logic [NODE_W-1:0] b, input logic [WEIGHT_IN_W-1:0] w);
    int gap;
    if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_req_type <= rt;
    in_node_a   <= a;
    in_node_b   <= b;
    in_weight   <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // only between phases: drain, let a sweep finish, then write the register
  task automatic set_node_count(input logic [CFG_W-1:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    node_limit = (val == 0) ? 1 : (val > MAX_N) ? MAX_N : int'(val);
  endtask

  task automatic random_item(output bit counted);
    int                     roll;
    logic [NODE_W-1:0]      a;
    logic [NODE_W-1:0]      b;
    logic [WEIGHT_IN_W-1:0] w;
    roll = $urandom_range(0, 99);
    a = NODE_W'($urandom_range(0, node_limit - 1));
    b = NODE_W'($urandom_range(0, node_limit - 1));
    // a small palette of weights so that ties are common
    case ($urandom_range(0, 3))
      0:       w = 16'h0000;
      1:       w = 16'hFFFF;
      2:       w = 16'($urandom_range(1, 3)) << 12;
      default: w = 16'($urandom);
    endcase
    counted = 1'b1;
    if (roll < ((node_limit <= 16) ? 8 : 3)) begin
      send(REQ_BUILD, a, b, w);
    end else if (roll < 10) begin
      send(REQ_CLEAR, a, b, w);
    end else if (roll < 11) begin
      send(REQ_UNKNOWN, a, b, w);
      counted = 1'b0;
    end else if (roll < 16) begin
      send(REQ_WRITE, a, a, w);
      counted = 1'b0;
    end else if (roll < 22) begin
      // endpoints anywhere in the matrix, past the node count too
      a = NODE_W'($urandom);
      b = NODE_W'($urandom);
      send(REQ_WRITE, a, b, w);
      counted = (a != b);
    end else begin
      send(REQ_WRITE, a, b, w);
      counted = (a != b);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] val;
    bit counted;
    int done;
    int stop_at;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_req_type = REQ_CLEAR;
    in_node_a   = '0;
    in_node_b   = '0;
    in_weight   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_node_count(6'd4);
    send(REQ_WRITE, 5'd0, 5'd1, 16'h1000);
    send(REQ_WRITE, 5'd2, 5'd2, 16'hFFFF);     // self edge, dropped
    send(REQ_WRITE, 5'd1, 5'd3, 16'hFFFF);
    send(REQ_WRITE, 5'd31, 5'd0, 16'h8000);    // outside the active nodes
    send(REQ_WRITE, 5'd0, 5'd2, 16'h0001);
    send(REQ_UNKNOWN, 5'd31, 5'd31, 16'hFFFF);
    send(REQ_BUILD, 5'd0, 5'd0, 16'h0000);
    send(REQ_WRITE, 5'd3, 5'd2, 16'h1000);     // ties the 0-1 edge
    send(REQ_BUILD, 5'd31, 5'd31, 16'hFFFF);
    send(REQ_CLEAR, 5'd0, 5'd0, 16'h0000);
    send(REQ_BUILD, 5'd0, 5'd0, 16'h0000);     // all weights tie at zero
    set_node_count(6'd1);
    send(REQ_BUILD, 5'd0, 5'd0, 16'h0000);
    set_node_count(6'd0);
    send(REQ_BUILD, 5'd0, 5'd0, 16'h0000);
    set_node_count(6'd63);
    send(REQ_WRITE, 5'd30, 5'd31, 16'hFFFF);
    send(REQ_BUILD, 5'd0, 5'd0, 16'h0000);
    set_node_count(6'd8);
    // hold the result side while requests keep coming
    long_hold = 1'b1;
    send(REQ_BUILD, 5'd0, 5'd0, 16'h0000);
    repeat (4) send(REQ_WRITE, NODE_W'($urandom_range(0, 7)), NODE_W'($urandom_range(0, 7)),
                    16'($urandom));
    send(REQ_BUILD, 5'd0, 5'd0, 16'h0000);

    done = 0;
    while (done < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 6))
            0:       val = 6'd0;
            1:       val = 6'd1;
            2:       val = 6'd2;
            3:       val = 6'd31;
            4:       val = 6'd32;
            5:       val = 6'd33;
            default: val = 6'd63;
          endcase
        end
        1, 2:    val = CFG_W'($urandom_range(9, 16));
        default: val = CFG_W'($urandom_range(2, 8));
      endcase
      set_node_count(val);
      calm = ($urandom_range(0, 3) == 0);
      stop_at = done + $urandom_range(30, 50);
      while (done < stop_at && done < RANDOM_ITEMS) begin
        if (done >= RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
        random_item(counted);
        done += counted;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
